// ===== src/modbus_rtu_register_slave_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU register slave checker
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH

// same-cycle implication
`define MBRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mbrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrs_pkg
// Constants, state codes and the CRC bit step for the Modbus RTU slave.
// ----------------------------------------------------------------------------
package mbrs_pkg;

  localparam int NUM_REGS     = 8;
  localparam int REG_AW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int REPLY_MAX    = 5 + 2 * NUM_REGS;
  localparam int IDX_W        = $clog2(REPLY_MAX + 1);
  localparam int HEADER_DEPTH = 6;
  localparam int HDR_AW       = 3;

  localparam logic [7:0]  FUNC_READ     = 8'h03;
  localparam logic [7:0]  FUNC_WRITE    = 8'h06;
  localparam logic [7:0]  RESET_ADDRESS = 8'h01;
  localparam logic [8:0]  LENGTH_MAX    = 9'd511;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_GAP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CRC  = 3'b010,
    ST_LOAD = 3'b100
  } mbrs_state_t;

  // one bit of the reflected CRC-16
  function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
    logic [15:0] sh;
    sh = {1'b0, crc[15:1]};
    return crc[0] ? (sh ^ CRC_POLY) : sh;
  endfunction

endpackage

// ===== src/modbus_rtu_register_slave.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave
// Modbus RTU slave (functions 03 and 06) over a small holding register bank.
// ----------------------------------------------------------------------------
// Feed received bytes (in_operation = 0) and a gap request (in_operation = 1)
// at the end of each frame. A single bit-serial CRC-16 unit (poly 0xA001,
// init 0xFFFF) does all checksum work, one bit per clock. The first two
// bytes of a frame are only stored; each later byte also hashes the oldest
// trailing byte (the CRC lags two bytes so the trailing CRC is never hashed).
// A gap checks the frame; if a reply is due, each reply data byte is loaded
// and then hashed bit by bit, and the two CRC bytes are loaded directly;
// out_ready can stall any of them. in_ready stays low until the last reply
// byte sits in the output register. Replies go out only for a matching
// non-zero address, good CRC, length of at least 4, in-range register span.
// device_address may be written through the cfg port at any time the block
// is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave
  import mbrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_device_address
);

  // control
  mbrs_state_t       state_r, state_nxt;
  logic [2:0]        bit_cnt_r, bit_cnt_nxt;
  logic              ret_load_r, ret_load_nxt;   // CRC done -> next reply byte
  logic [15:0]       crc_r, crc_nxt;             // shared by frame check and reply
  logic [8:0]        frame_len_r, frame_len_nxt;
  logic [7:0]        trail_r [2];
  logic [7:0]        trail_nxt [2];
  logic [7:0]        dev_addr_r, dev_addr_nxt;
  logic              is_read_r, is_read_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  body_len_r, body_len_nxt;
  logic [REG_AW-1:0] rd_ptr_r, rd_ptr_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  // storage
  logic [7:0]        hdr_r [HEADER_DEPTH];
  logic [15:0]       hold_regs_r [NUM_REGS];

  logic              in_acc, out_acc;
  logic              hdr_we;
  logic              hr_we;
  logic [REG_AW-1:0] hr_wa;
  logic [15:0]       hr_wd;

  logic              gap_ok, read_ok, write_ok;
  logic [15:0]       start_addr, arg_val;
  logic [16:0]       span_end;
  logic [15:0]       rd_val;
  logic [7:0]        body_byte;
  logic              out_free;

  assign in_ready      = (state_r == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_last_byte = out_last_r;

  assign in_acc   = in_valid & in_ready;
  assign out_acc  = out_valid_r & out_ready;
  assign out_free = ~out_valid_r | out_ready;

  // frame qualification at the gap
  assign start_addr = {hdr_r[2], hdr_r[3]};
  assign arg_val    = {hdr_r[4], hdr_r[5]};
  assign span_end   = {1'b0, start_addr} + {1'b0, arg_val};
  assign gap_ok     = (frame_len_r >= 9'd4) && ({trail_r[1], trail_r[0]} == crc_r) &&
                      (hdr_r[0] != 8'h00) && (hdr_r[0] == dev_addr_r);
  assign read_ok    = gap_ok && (hdr_r[1] == FUNC_READ) && (arg_val != 16'd0) &&
                      (span_end <= 17'(NUM_REGS));
  assign write_ok   = gap_ok && (hdr_r[1] == FUNC_WRITE) && (start_addr < 16'(NUM_REGS));

  assign rd_val = hold_regs_r[rd_ptr_r];

  // reply body byte selected by position
  always_comb begin
    body_byte = 8'h00;
    if (idx_r == IDX_W'(0)) begin
      body_byte = dev_addr_r;
    end else if (idx_r == IDX_W'(1)) begin
      body_byte = is_read_r ? FUNC_READ : FUNC_WRITE;
    end else if (is_read_r) begin
      if (idx_r == IDX_W'(2)) begin
        body_byte = {arg_val[6:0], 1'b0};
      end else begin
        body_byte = idx_r[0] ? rd_val[15:8] : rd_val[7:0];
      end
    end else begin
      case (idx_r)
        IDX_W'(2): body_byte = hdr_r[2];
        IDX_W'(3): body_byte = hdr_r[3];
        IDX_W'(4): body_byte = hdr_r[4];
        IDX_W'(5): body_byte = hdr_r[5];
        default:   body_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    ret_load_nxt  = ret_load_r;
    crc_nxt       = crc_r;
    frame_len_nxt = frame_len_r;
    trail_nxt[0]  = trail_r[0];
    trail_nxt[1]  = trail_r[1];
    dev_addr_nxt  = dev_addr_r;
    is_read_nxt   = is_read_r;
    idx_nxt       = idx_r;
    body_len_nxt  = body_len_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    hdr_we        = 1'b0;
    hr_we         = 1'b0;
    hr_wa         = start_addr[REG_AW-1:0];
    hr_wd         = arg_val;

    if (cfg_valid && cfg_ready) begin
      dev_addr_nxt = cfg_device_address;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_operation == OP_BYTE)) begin
          if (frame_len_r >= 9'd2) begin
            crc_nxt      = crc_r ^ {8'h00, trail_r[0]};
            bit_cnt_nxt  = 3'd0;
            ret_load_nxt = 1'b0;
            state_nxt    = ST_CRC;
          end
          trail_nxt[0] = trail_r[1];
          trail_nxt[1] = in_rx_byte;
          hdr_we       = (frame_len_r < 9'(HEADER_DEPTH));
          if (frame_len_r != LENGTH_MAX) begin
            frame_len_nxt = frame_len_r + 9'd1;
          end
        end else if (in_acc) begin
          // gap: qualify, start reply, clear frame state
          is_read_nxt   = read_ok;
          idx_nxt       = '0;
          rd_ptr_nxt    = start_addr[REG_AW-1:0];
          body_len_nxt  = read_ok ? IDX_W'({arg_val, 1'b0} + 17'd3) : IDX_W'(6);
          hr_we         = write_ok;
          crc_nxt       = CRC_INIT;
          frame_len_nxt = '0;
          trail_nxt[0]  = 8'h00;
          trail_nxt[1]  = 8'h00;
          if (read_ok || write_ok) begin
            state_nxt = ST_LOAD;
          end
        end
      end

      ST_CRC: begin
        crc_nxt     = crc_bit_step(crc_r);
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          state_nxt = ret_load_r ? ST_LOAD : ST_IDLE;
        end
      end

      ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          idx_nxt       = idx_r + IDX_W'(1);
          if (idx_r == body_len_r) begin
            out_byte_nxt = crc_r[7:0];
            out_last_nxt = 1'b0;
          end else if (idx_r == body_len_r + IDX_W'(1)) begin
            out_byte_nxt = crc_r[15:8];
            out_last_nxt = 1'b1;
            crc_nxt      = CRC_INIT;
            state_nxt    = ST_IDLE;
          end else begin
            out_byte_nxt = body_byte;
            out_last_nxt = 1'b0;
            crc_nxt      = crc_r ^ {8'h00, body_byte};
            bit_cnt_nxt  = 3'd0;
            ret_load_nxt = 1'b1;
            state_nxt    = ST_CRC;
            // low byte of a register read done: advance pointer
            if (is_read_r && (idx_r > IDX_W'(2)) && !idx_r[0]) begin
              rd_ptr_nxt = rd_ptr_r + REG_AW'(1);
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_cnt_r   <= '0;
      ret_load_r  <= 1'b0;
      crc_r       <= CRC_INIT;
      frame_len_r <= '0;
      trail_r[0]  <= 8'h00;
      trail_r[1]  <= 8'h00;
      dev_addr_r  <= RESET_ADDRESS;
      is_read_r   <= 1'b0;
      idx_r       <= '0;
      body_len_r  <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        hold_regs_r[i] <= 16'(i + 1);
      end
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      ret_load_r  <= ret_load_nxt;
      crc_r       <= crc_nxt;
      frame_len_r <= frame_len_nxt;
      trail_r[0]  <= trail_nxt[0];
      trail_r[1]  <= trail_nxt[1];
      dev_addr_r  <= dev_addr_nxt;
      is_read_r   <= is_read_nxt;
      idx_r       <= idx_nxt;
      body_len_r  <= body_len_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (hr_we) begin
        hold_regs_r[hr_wa] <= hr_wd;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (hdr_we) begin
      hdr_r[frame_len_r[HDR_AW-1:0]] <= in_rx_byte;
    end
  end

endmodule

// ===== src/mbrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrs_checker
// Port-level checks on the Modbus RTU slave, bound to the top level.
// ----------------------------------------------------------------------------
`include "modbus_rtu_register_slave_macros.svh"

module mbrs_checker
  import mbrs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_operation,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_last_byte
);

  // a stalled reply byte holds
  `MBRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tx_byte) && $stable(out_last_byte), "reply byte changed while stalled")

  // mid-reply, no new request is taken
  `MBRS_ASSERT_IMPL(a_busy_mid_reply, out_valid && !out_last_byte, !in_ready, "request taken during reply")

  // once a non-final reply byte leaves, more reply follows before new input
  `MBRS_ASSERT_NEXT(a_reply_continues, out_valid && out_ready && !out_last_byte, out_valid || !in_ready, "reply ended without a last byte")

  // a byte request with no gap never produces output from idle with nothing pending
  `MBRS_ASSERT_NEXT(a_byte_no_reply, in_valid && in_ready && (in_operation == OP_BYTE) && !out_valid, !out_valid, "byte request produced a reply")

endmodule

bind modbus_rtu_register_slave mbrs_checker u_mbrs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_tx_byte  (out_tx_byte),
  .out_last_byte(out_last_byte)
);
